/* rtl/core/two_motor_window_sequencer_core_assert.svh */
// Assertion macros shared by the window sequencer RTL.
`ifndef TWO_MOTOR_WINDOW_SEQUENCER_CORE_ASSERT_SVH
`define TWO_MOTOR_WINDOW_SEQUENCER_CORE_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset.
`define TWMWS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a trigger is followed in the next cycle by a consequence.
`define TWMWS_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define TWMWS_ASSERT_IMPL(label, clk, rst_n, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/twmws_pkg.sv */
// Types, codes and reset values shared by the window sequencer modules.
`timescale 1ns / 1ps
`default_nettype none

package twmws_pkg;

    // Field widths
    localparam int CUR_W    = 12;
    localparam int TICK_W   = 32;
    localparam int MS_W     = 16;
    localparam int PHASE_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 16;
    localparam int IN_W     = 64;
    localparam int OUT_W    = 8;

    // Sequencer phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LOWER_ONE = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LOWER_TWO = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RAISE_TWO = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RAISE_ONE = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INRUSH_BLANK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_LIMIT = 2'd2;

    // Configuration reset values
    localparam logic [MS_W-1:0]  RUN_TIMEOUT_RST  = 16'd6000;
    localparam logic [MS_W-1:0]  INRUSH_BLANK_RST = 16'd300;
    localparam logic [CUR_W-1:0] STALL_LIMIT_RST  = 12'd2048;

    typedef struct packed {
        logic [MS_W-1:0]  run_timeout_ms;
        logic [MS_W-1:0]  inrush_blank_ms;
        logic [CUR_W-1:0] stall_current_limit;
    } twmws_cfg_t;

    typedef struct packed {
        logic              btn_raise_auto;
        logic              btn_raise;
        logic              btn_lower_auto;
        logic              btn_lower;
        logic [CUR_W-1:0]  current_one;
        logic [CUR_W-1:0]  current_two;
        logic [TICK_W-1:0] tick_now;
    } twmws_item_t;

    typedef struct packed {
        logic [PHASE_W-1:0] seq_phase;
        logic               auto_latched;
        logic [TICK_W-1:0]  phase_start_tick;
    } twmws_state_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               auto_active;
        logic               stop_hit;
    } twmws_result_t;

endpackage

`default_nettype wire

/* rtl/core/twmws_step.sv */
// One sequencer step: next state and result from the current state and one tick.
`timescale 1ns / 1ps
`default_nettype none

module twmws_step
    import twmws_pkg::*;
(
    input  wire twmws_cfg_t   cfg,
    input  wire twmws_state_t state,
    input  wire twmws_item_t  item,
    output twmws_state_t      state_next,
    output twmws_result_t     result
);

    logic                is_raise;
    logic                is_lower;
    logic                lower_auto_cmd;
    logic                released;
    logic [PHASE_W-1:0]  eff_phase;
    logic [TICK_W-1:0]   elapsed;
    logic                over_time;
    logic                in_blank;
    logic                stalled;
    logic                must_stop;
    logic                stop;

    // Priority-encode the buttons into a direction
    assign is_raise       = item.btn_raise_auto | item.btn_raise;
    assign is_lower       = ~is_raise & (item.btn_lower_auto | item.btn_lower);
    assign lower_auto_cmd = ~is_raise & item.btn_lower_auto;
    assign released       = ~state.auto_latched & ~is_raise & ~is_lower;

    // Stop test on the wrapping elapsed time
    assign elapsed   = item.tick_now - state.phase_start_tick;
    assign over_time = elapsed > {{(TICK_W-MS_W){1'b0}}, cfg.run_timeout_ms};
    assign in_blank  = elapsed < {{(TICK_W-MS_W){1'b0}}, cfg.inrush_blank_ms};
    assign stalled   = (item.current_one > cfg.stall_current_limit)
                     | (item.current_two > cfg.stall_current_limit);
    assign must_stop = over_time | (~in_blank & stalled);

    // Cancel an auto sequence on an opposite press
    always_comb
    begin
        eff_phase = state.seq_phase;
        if (state.auto_latched)
        begin
            if (((state.seq_phase == PH_LOWER_ONE) || (state.seq_phase == PH_LOWER_TWO))
                && is_raise)
            begin
                eff_phase = PH_IDLE;
            end
            if (((state.seq_phase == PH_RAISE_TWO) || (state.seq_phase == PH_RAISE_ONE))
                && is_lower)
            begin
                eff_phase = PH_IDLE;
            end
        end
    end

    // Advance the sequencer
    always_comb
    begin
        state_next           = state;
        state_next.seq_phase = eff_phase;
        stop                 = 1'b0;
        unique case (eff_phase) inside
            PH_IDLE:
            begin
                state_next.auto_latched = 1'b0;
                if (is_lower)
                begin
                    state_next.auto_latched     = lower_auto_cmd;
                    state_next.phase_start_tick = item.tick_now;
                    state_next.seq_phase        = PH_LOWER_ONE;
                end
                else if (is_raise)
                begin
                    state_next.auto_latched     = item.btn_raise_auto;
                    state_next.phase_start_tick = item.tick_now;
                    state_next.seq_phase        = PH_RAISE_TWO;
                end
            end
            PH_LOWER_ONE, PH_RAISE_TWO:
            begin
                if (released)
                begin
                    state_next.seq_phase = PH_IDLE;
                end
                else if (must_stop)
                begin
                    stop                        = 1'b1;
                    state_next.phase_start_tick = item.tick_now;
                    state_next.seq_phase = (eff_phase == PH_LOWER_ONE) ? PH_LOWER_TWO
                                                                       : PH_RAISE_ONE;
                end
            end
            PH_LOWER_TWO, PH_RAISE_ONE:
            begin
                if (released)
                begin
                    state_next.seq_phase = PH_IDLE;
                end
                else if (must_stop)
                begin
                    stop                 = 1'b1;
                    state_next.seq_phase = PH_IDLE;
                end
            end
            default:
            begin
                state_next.seq_phase = PH_IDLE;
            end
        endcase
    end

    assign result.phase       = state_next.seq_phase;
    assign result.auto_active = state_next.auto_latched;
    assign result.stop_hit    = stop;

endmodule

`default_nettype wire

/* rtl/core/two_motor_window_sequencer_core.sv */
// Top level of the two-motor window sequencer: handshake, registers and checks.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Each slave transaction is one control tick: four button bits, two 12-bit
//   motor current samples and a 32-bit millisecond timestamp. Each tick yields
//   exactly one master transaction with the phase after the tick, the auto
//   flag and a stop flag.
//   The tick is captured in an input register at the accepting edge and is
//   stepped through the sequencer into the output register once that register
//   is free, which raises m_tvalid. One tick is taken every cycle while m_tready is high.
//   When the receiver holds m_tready low, the output register keeps its
//   transaction and one more tick may wait in the input register; after that
//   s_tready drops until the output drains.
//   Reset clears both valid flags, the sequencer state (idle, manual, start
//   tick zero) and loads the default timeout, blanking time and stall limit.
//   The cfg port writes one register per edge with cfg_we high; write only
//   while no tick is in flight. Indexes beyond the last register are ignored.
module two_motor_window_sequencer_core
    import twmws_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // slave tick channel
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    // [0] btn_raise_auto, [1] btn_raise, [2] btn_lower_auto, [3] btn_lower,
    // [15:4] current_one, [27:16] current_two, [59:28] tick_now, [63:60] zero
    input  wire logic [IN_W-1:0]      s_tdata,
    // master result channel
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // [2:0] phase, [3] auto_active, [4] stop_hit, [7:5] zero
    output      logic [OUT_W-1:0]     m_tdata,
    // configuration write port
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    twmws_cfg_t    cfg_reg;
    twmws_state_t  state_reg;
    twmws_state_t  state_next;
    twmws_item_t   in_item_reg;
    logic          in_valid_reg;
    twmws_result_t out_reg;
    twmws_result_t step_result;
    logic          out_valid_reg;
    logic          out_free;
    logic          step_adv;
    logic          in_take;
    logic          phase_legal;
    logic          stop_seen;
    logic          stop_target_ok;
    logic          idle_auto;
    logic          start_taken;
    logic          start_tick_ok;

    // Handshake between the two register stages
    assign out_free = ~out_valid_reg | m_tready;
    assign step_adv = in_valid_reg & out_free;
    assign s_tready = ~in_valid_reg | out_free;
    assign in_take  = s_tvalid & s_tready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_timeout_ms      <= RUN_TIMEOUT_RST;
            cfg_reg.inrush_blank_ms     <= INRUSH_BLANK_RST;
            cfg_reg.stall_current_limit <= STALL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RUN_TIMEOUT:  cfg_reg.run_timeout_ms      <= cfg_wdata;
                CFG_INRUSH_BLANK: cfg_reg.inrush_blank_ms     <= cfg_wdata;
                CFG_STALL_LIMIT:  cfg_reg.stall_current_limit <= cfg_wdata[CUR_W-1:0];
                default:          ;
            endcase
        end
    end

    // Capture the incoming tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.btn_raise_auto <= s_tdata[0];
            in_item_reg.btn_raise      <= s_tdata[1];
            in_item_reg.btn_lower_auto <= s_tdata[2];
            in_item_reg.btn_lower      <= s_tdata[3];
            in_item_reg.current_one    <= s_tdata[15:4];
            in_item_reg.current_two    <= s_tdata[27:16];
            in_item_reg.tick_now       <= s_tdata[59:28];
        end
    end

    twmws_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Advance the sequencer state as each tick moves to the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.seq_phase        <= PH_IDLE;
            state_reg.auto_latched     <= 1'b0;
            state_reg.phase_start_tick <= '0;
        end
        else if (step_adv)
        begin
            state_reg <= state_next;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_adv)
        begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.stop_hit, out_reg.auto_active, out_reg.phase};

    // Checks on the sequencer logic
    assign phase_legal    = (state_reg.seq_phase == PH_IDLE)
                          || (state_reg.seq_phase == PH_LOWER_ONE)
                          || (state_reg.seq_phase == PH_LOWER_TWO)
                          || (state_reg.seq_phase == PH_RAISE_TWO)
                          || (state_reg.seq_phase == PH_RAISE_ONE);
    assign stop_seen      = out_valid_reg && out_reg.stop_hit;
    assign stop_target_ok = (out_reg.phase == PH_LOWER_TWO) || (out_reg.phase == PH_RAISE_ONE)
                          || (out_reg.phase == PH_IDLE);
    // Auto stays latched in idle only when a stop ended the second phase
    assign idle_auto      = out_valid_reg && out_reg.auto_active && (out_reg.phase == PH_IDLE);
    assign start_taken    = step_adv && (state_reg.seq_phase == PH_IDLE)
                          && (state_next.seq_phase != PH_IDLE);
    assign start_tick_ok  = state_next.phase_start_tick == in_item_reg.tick_now;

`include "two_motor_window_sequencer_core_assert.svh"

    `TWMWS_ASSERT_ALWAYS(a_phase_legal, clk, rst_n, phase_legal, "illegal sequencer phase")
    `TWMWS_ASSERT_IMPL(a_stop_target, clk, rst_n, stop_seen, stop_target_ok, "bad stop phase")
    `TWMWS_ASSERT_IMPL(a_idle_auto, clk, rst_n, idle_auto, out_reg.stop_hit, "stray auto flag")
    `TWMWS_ASSERT_IMPL(a_start_tick, clk, rst_n, start_taken, start_tick_ok, "start tick lost")
    `TWMWS_ASSERT_NEXT(a_state_hold, clk, rst_n, !step_adv, $stable(state_reg), "state changed")

endmodule

`default_nettype wire

/* bench/window_sequencer_checker.sv */
// Watches both tick channels and the register port, predicts each result and compares it.
`timescale 1ns / 1ps

module window_sequencer_checker
    import twmws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_W-1:0]      s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   mismatches,
    output int                   awaiting
);

    // Priority-encoded button command
    typedef enum logic [2:0] {
        CMD_REST,
        CMD_RAISE_AUTO,
        CMD_RAISE,
        CMD_LOWER_AUTO,
        CMD_LOWER
    } window_cmd_t;

    twmws_cfg_t    limits;
    twmws_state_t  win;
    twmws_result_t pending_results[$];

    function automatic window_cmd_t decode_buttons(input twmws_item_t t);
        if (t.btn_raise_auto) return CMD_RAISE_AUTO;
        if (t.btn_raise)      return CMD_RAISE;
        if (t.btn_lower_auto) return CMD_LOWER_AUTO;
        if (t.btn_lower)      return CMD_LOWER;
        return CMD_REST;
    endfunction

    // Timeout wins over blanking; stall only counts once blanking has passed
    function automatic logic stop_due(input logic [TICK_W-1:0] now,
                                      input logic [CUR_W-1:0] c1,
                                      input logic [CUR_W-1:0] c2);
        logic [TICK_W-1:0] elapsed;
        elapsed = now - win.phase_start_tick;
        if (elapsed > {16'd0, limits.run_timeout_ms}) return 1'b1;
        if (elapsed < {16'd0, limits.inrush_blank_ms}) return 1'b0;
        return (c1 > limits.stall_current_limit) || (c2 > limits.stall_current_limit);
    endfunction

    // Step the sequencer by one tick and return the result it yields
    function automatic twmws_result_t advance_window(input twmws_item_t t);
        window_cmd_t   cmd;
        logic          going_up;
        logic          going_down;
        logic          released;
        logic          stop;
        twmws_result_t r;
        cmd        = decode_buttons(t);
        going_up   = (cmd == CMD_RAISE) || (cmd == CMD_RAISE_AUTO);
        going_down = (cmd == CMD_LOWER) || (cmd == CMD_LOWER_AUTO);
        released   = !win.auto_latched && (cmd == CMD_REST);
        stop       = 1'b0;

        // An opposite press cancels an automatic run before the phase logic
        if (win.auto_latched) begin
            if ((win.seq_phase == PH_LOWER_ONE || win.seq_phase == PH_LOWER_TWO) && going_up)
                win.seq_phase = PH_IDLE;
            if ((win.seq_phase == PH_RAISE_TWO || win.seq_phase == PH_RAISE_ONE) && going_down)
                win.seq_phase = PH_IDLE;
        end

        case (win.seq_phase)
            PH_IDLE:
            begin
                win.auto_latched = 1'b0;
                if (going_down) begin
                    win.auto_latched     = (cmd == CMD_LOWER_AUTO);
                    win.phase_start_tick = t.tick_now;
                    win.seq_phase        = PH_LOWER_ONE;
                end
                else if (going_up) begin
                    win.auto_latched     = (cmd == CMD_RAISE_AUTO);
                    win.phase_start_tick = t.tick_now;
                    win.seq_phase        = PH_RAISE_TWO;
                end
            end
            PH_LOWER_ONE, PH_RAISE_TWO:
            begin
                if (released) begin
                    win.seq_phase = PH_IDLE;
                end
                else if (stop_due(t.tick_now, t.current_one, t.current_two)) begin
                    stop                 = 1'b1;
                    win.phase_start_tick = t.tick_now;
                    win.seq_phase = (win.seq_phase == PH_LOWER_ONE) ? PH_LOWER_TWO : PH_RAISE_ONE;
                end
            end
            PH_LOWER_TWO, PH_RAISE_ONE:
            begin
                if (released) begin
                    win.seq_phase = PH_IDLE;
                end
                else if (stop_due(t.tick_now, t.current_one, t.current_two)) begin
                    stop          = 1'b1;
                    win.seq_phase = PH_IDLE;
                end
            end
            default:
            begin
                win.seq_phase = PH_IDLE;
            end
        endcase

        r.phase       = win.seq_phase;
        r.auto_active = win.auto_latched;
        r.stop_hit    = stop;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        twmws_item_t   tick;
        twmws_result_t want;
        twmws_result_t got;
        if (!rst_n) begin
            limits.run_timeout_ms      = RUN_TIMEOUT_RST;
            limits.inrush_blank_ms     = INRUSH_BLANK_RST;
            limits.stall_current_limit = STALL_LIMIT_RST;
            win.seq_phase              = PH_IDLE;
            win.auto_latched           = 1'b0;
            win.phase_start_tick       = '0;
            pending_results.delete();
            mismatches = 0;
            awaiting  <= 0;
        end
        else begin
            // Track register writes; unused indexes change nothing
            if (cfg_we) begin
                case (cfg_index)
                    CFG_RUN_TIMEOUT:  limits.run_timeout_ms      = cfg_wdata;
                    CFG_INRUSH_BLANK: limits.inrush_blank_ms     = cfg_wdata;
                    CFG_STALL_LIMIT:  limits.stall_current_limit = cfg_wdata[CUR_W-1:0];
                    default: ;
                endcase
            end

            // Compare each result transaction with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.phase       = m_tdata[2:0];
                got.auto_active = m_tdata[3];
                got.stop_hit    = m_tdata[4];
                if (pending_results.size() == 0) begin
                    $error("result with no tick outstanding: m_tdata=%h", m_tdata);
                    mismatches++;
                end
                else begin
                    want = pending_results.pop_front();
                    if (got.phase !== want.phase) begin
                        $error("phase: expected %0d, got %0d", want.phase, got.phase);
                        mismatches++;
                    end
                    if (got.auto_active !== want.auto_active) begin
                        $error("auto_active: expected %0d, got %0d",
                               want.auto_active, got.auto_active);
                        mismatches++;
                    end
                    if (got.stop_hit !== want.stop_hit) begin
                        $error("stop_hit: expected %0d, got %0d", want.stop_hit, got.stop_hit);
                        mismatches++;
                    end
                    if (m_tdata[7:5] !== 3'd0) begin
                        $error("tdata pad: expected 0, got %0d", m_tdata[7:5]);
                        mismatches++;
                    end
                end
            end

            // Predict the result of each accepted tick
            if (s_tvalid && s_tready) begin
                tick.btn_raise_auto = s_tdata[0];
                tick.btn_raise      = s_tdata[1];
                tick.btn_lower_auto = s_tdata[2];
                tick.btn_lower      = s_tdata[3];
                tick.current_one    = s_tdata[15:4];
                tick.current_two    = s_tdata[27:16];
                tick.tick_now       = s_tdata[59:28];
                pending_results.push_back(advance_window(tick));
            end

            awaiting <= pending_results.size();
        end
    end

endmodule

/* bench/testbench.sv */
// Top of the window sequencer bench: clock, reset, tick stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module testbench;
    import twmws_pkg::*;

    // Button patterns as packed in tdata bits [3:0]
    localparam logic [3:0] BTN_NONE       = 4'b0000;
    localparam logic [3:0] BTN_RAISE_AUTO = 4'b0001;
    localparam logic [3:0] BTN_RAISE      = 4'b0010;
    localparam logic [3:0] BTN_LOWER_AUTO = 4'b0100;
    localparam logic [3:0] BTN_LOWER      = 4'b1000;
    localparam logic [3:0] BTN_ALL        = 4'b1111;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int RANDOM_PER_SETTING = 260;
    localparam int HOLD_AT            = 200;
    localparam int HOLD_CYCLES        = 60;
    localparam int QUIET_LIMIT        = 2000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int mismatches;
    int awaiting;

    int          ticks_sent = 0;
    int          results_taken = 0;
    int          quiet_cycles = 0;
    logic [31:0] clock_ms = 32'd0;
    logic [3:0]  gesture = BTN_NONE;
    int          hold_left = 0;
    int          shape_timeout = RUN_TIMEOUT_RST;
    int          shape_limit = STALL_LIMIT_RST;

    always #1 clk = ~clk;

    two_motor_window_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    window_sequencer_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    // Offer one tick after a random gap and hold it until accepted
    task automatic drive_tick(input logic [3:0] btns, input logic [CUR_W-1:0] c1,
                              input logic [CUR_W-1:0] c2, input logic [TICK_W-1:0] now);
        int unsigned gap;
        gap = ((ticks_sent / 40) % 4 == 3) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, now, c2, c1, btns};
        do @(posedge clk); while (!s_tready);
        ticks_sent++;
    endtask

    // Drain the block, then load all three limits and, if asked, poke the unused index
    task automatic configure(input logic [MS_W-1:0] run_ms, input logic [MS_W-1:0] blank_ms,
                             input logic [CUR_W-1:0] limit, input bit poke_unused);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (awaiting != 0);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RUN_TIMEOUT;
        cfg_wdata <= run_ms;
        @(posedge clk);
        cfg_index <= CFG_INRUSH_BLANK;
        cfg_wdata <= blank_ms;
        @(posedge clk);
        cfg_index <= CFG_STALL_LIMIT;
        cfg_wdata <= {4'($urandom_range(0, 15)), limit};
        @(posedge clk);
        if (poke_unused) begin
            cfg_index <= CFG_UNUSED;
            cfg_wdata <= 16'($urandom_range(0, 65535));
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        shape_timeout = run_ms;
        shape_limit   = limit;
    endtask

    // Mostly at or below the stall limit, with some overcurrent and some full-range noise
    function automatic logic [CUR_W-1:0] draw_current();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 12'($urandom());
        if (roll <= 2) return 12'($urandom_range(shape_limit, 4095));
        return 12'($urandom_range(0, shape_limit));
    endfunction

    // Advance the millisecond clock: small steps mostly, with jumps and wraps
    task automatic step_clock();
        int unsigned roll;
        roll = $urandom_range(0, 39);
        if (roll == 0)
            clock_ms = $urandom();
        else if (roll == 1)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 40);
        else if (roll <= 3)
            clock_ms = clock_ms + $urandom_range(0, 70000);
        else
            clock_ms = clock_ms + $urandom_range(0, shape_timeout / 8 + 2);
    endtask

    // Button gestures: holds, auto pulses, rests and noise
    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (hold_left == 0) begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        gesture   = BTN_NONE;
                        hold_left = $urandom_range(1, 6);
                    end
                    2, 7:
                    begin
                        gesture   = BTN_LOWER;
                        hold_left = $urandom_range(1, 25);
                    end
                    3, 8:
                    begin
                        gesture   = BTN_RAISE;
                        hold_left = $urandom_range(1, 25);
                    end
                    4:
                    begin
                        gesture   = BTN_LOWER_AUTO;
                        hold_left = $urandom_range(1, 3);
                    end
                    5:
                    begin
                        gesture   = BTN_RAISE_AUTO;
                        hold_left = $urandom_range(1, 3);
                    end
                    6:
                    begin
                        gesture   = 4'($urandom_range(0, 15));
                        hold_left = $urandom_range(1, 4);
                    end
                    default:
                    begin
                        gesture   = BTN_NONE;
                        hold_left = $urandom_range(1, 30);
                    end
                endcase
            end
            hold_left--;
            step_clock();
            drive_tick(gesture, draw_current(), draw_current(), clock_ms);
        end
    endtask

    // Receiver: random stalls per result, calm stretches, one long hold-off
    initial
    begin
        int unsigned gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (results_taken == HOLD_AT)
                gap = HOLD_CYCLES;
            else if ((results_taken / 40) % 4 == 3)
                gap = 0;
            else
                gap = $urandom_range(0, 17);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            results_taken++;
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $error("no transaction for %0d cycles", QUIET_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks under the reset limits (6000 ms, 300 ms, 2048)
        drive_tick(BTN_NONE,       12'd0,    12'd0,    32'd0);
        drive_tick(BTN_LOWER,      12'd100,  12'd100,  32'd100);
        drive_tick(BTN_LOWER,      12'd4095, 12'd4095, 32'd200);   // inrush blanked
        drive_tick(BTN_LOWER,      12'd4095, 12'd0,    32'd400);   // stall on motor one
        drive_tick(BTN_NONE,       12'd0,    12'd0,    32'd401);   // manual release
        drive_tick(BTN_ALL,        12'd0,    12'd0,    32'd1000);  // priority: raise auto
        drive_tick(BTN_NONE,       12'd2048, 12'd2048, 32'd1500);  // at limit, no stall
        drive_tick(BTN_NONE,       12'd10,   12'd10,   32'd7000);  // at timeout, no stop
        drive_tick(BTN_NONE,       12'd10,   12'd10,   32'd7001);  // timeout
        drive_tick(BTN_LOWER,      12'd0,    12'd0,    32'd7002);  // opposite press in auto
        drive_tick(BTN_RAISE,      12'd0,    12'd0,    32'd7003);  // opposite press in manual
        drive_tick(BTN_RAISE_AUTO, 12'd0,    12'd0,    32'd7004);
        drive_tick(BTN_NONE,       12'd0,    12'd0,    32'd7005);
        drive_tick(BTN_LOWER_AUTO, 12'd0,    12'd0,    32'hFFFF_FFF0);
        drive_tick(BTN_NONE,       12'd4095, 12'd4095, 32'h0000_0010); // wrapped, blanked
        drive_tick(BTN_NONE,       12'd0,    12'd4095, 32'h0000_0140); // stall on motor two
        drive_tick(BTN_LOWER_AUTO, 12'd0,    12'd0,    32'h0000_01A4);
        drive_tick(BTN_NONE,       12'd0,    12'd0,    32'h0000_18B1); // timeout to idle
        drive_tick(BTN_NONE,       12'd0,    12'd0,    32'h0000_18B2); // idle clears auto
        drive_tick(BTN_RAISE_AUTO, 12'd0,    12'd0,    32'h8000_0000);
        drive_tick(BTN_LOWER_AUTO, 12'd0,    12'd0,    32'h8000_0001);
        drive_tick(BTN_RAISE,      12'd0,    12'd0,    32'h8000_0002);
        drive_tick(BTN_NONE,       12'd0,    12'd0,    32'h8000_0003);
        drive_tick(BTN_RAISE,      12'd4095, 12'd4095, 32'hFFFF_FFFF);
        drive_tick(BTN_RAISE,      12'd4095, 12'd4095, 32'h0000_012B); // blank just over

        run_random(RANDOM_PER_SETTING);
        configure(16'd20, 16'd5, 12'd1000, 1'b0);
        run_random(RANDOM_PER_SETTING);
        configure(16'd0, 16'd0, 12'd0, 1'b1);
        run_random(RANDOM_PER_SETTING);
        configure(16'd65535, 16'd65535, 12'd4095, 1'b0);
        run_random(RANDOM_PER_SETTING);
        configure(16'($urandom_range(1, 300)), 16'($urandom_range(0, 300)),
                  12'($urandom_range(0, 4095)), 1'b0);
        run_random(RANDOM_PER_SETTING);

        // Let the last results drain
        s_tvalid <= 1'b0;
        do @(posedge clk); while (awaiting != 0);
        repeat (8) @(posedge clk);

        $display("Covered %0d ticks and %0d results under five limit settings,",
                 ticks_sent, results_taken);
        $display("from all-zero to full-scale, with a %0d-cycle output hold-off.", HOLD_CYCLES);
        if (mismatches == 0 && awaiting == 0) begin
            $display("SCOREBOARD CLEAN");
        end
        else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
